### rtl/rpu_pkg.sv
// shared types, codes and arithmetic helpers for the raster pixel unpacker
`timescale 1ns / 1ps

package rpu_pkg;

    localparam logic [2:0] PSM_1BIT  = 3'd0;
    localparam logic [2:0] PSM_4BIT  = 3'd1;
    localparam logic [2:0] PSM_8BIT  = 3'd2;
    localparam logic [2:0] PSM_16BIT = 3'd3;
    localparam logic [2:0] PSM_24BIT = 3'd4;
    localparam logic [2:0] PSM_32BIT = 3'd5;

    localparam logic [1:0] FMT_LUMA = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_RGBA = 2'd2;

    localparam logic [2:0] REG_PIXEL_SIZE_MODE = 3'd0;
    localparam logic [2:0] REG_OUTPUT_FORMAT   = 3'd1;
    localparam logic [2:0] REG_UYVY_MODE       = 3'd2;
    localparam logic [2:0] REG_SWAP_BGR        = 3'd3;
    localparam logic [2:0] REG_ALPHA_VALUE     = 3'd4;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    localparam logic signed [18:0] K_Y  = 19'sd76284;
    localparam logic signed [18:0] K_RV = 19'sd104595;
    localparam logic signed [18:0] K_GV = 19'sd53281;
    localparam logic signed [18:0] K_GU = 19'sd25625;
    localparam logic signed [18:0] K_BU = 19'sd132252;
    localparam logic signed [29:0] K_ROUND = 30'sd32768;

    localparam logic [2:0] BYTES_LUMA = 3'd1;
    localparam logic [2:0] BYTES_RGB  = 3'd3;
    localparam logic [2:0] BYTES_RGBA = 3'd4;

    typedef struct packed {
        logic [2:0] pixel_size_mode;
        logic [1:0] output_format;
        logic       uyvy_mode;
        logic       swap_bgr;
        logic [7:0] alpha_value;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic [2:0]         start;
        logic [2:0]         last_idx;
        logic signed [28:0] y_p;
        logic signed [28:0] rv_p;
        logic signed [28:0] gv_p;
        logic signed [28:0] gu_p;
        logic signed [28:0] bu_p;
    } t_item;

    function automatic logic [7:0] clamp_channel(input logic signed [29:0] acc);
        logic signed [29:0] x;
        logic [7:0]         res;
        x = acc + K_ROUND;
        if (x[29]) begin
            res = 8'd0;
        end else if (x[28:24] != 5'd0) begin
            res = 8'hFF;
        end else begin
            res = x[23:16];
        end
        return res;
    endfunction

endpackage

### rtl/rpu_cfg.sv
// apb configuration registers
`timescale 1ns / 1ps

module rpu_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpu_pkg::PADDR_W-1:0]  paddr,
    input  logic [rpu_pkg::PDATA_W-1:0]  pwdata,
    output logic [rpu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output rpu_pkg::t_cfg                o_cfg
);

    rpu_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_size_mode <= rpu_pkg::PSM_8BIT;
            r_cfg.output_format   <= rpu_pkg::FMT_LUMA;
            r_cfg.uyvy_mode       <= 1'b0;
            r_cfg.swap_bgr        <= 1'b0;
            r_cfg.alpha_value     <= 8'hFF;
        end else if (wr_en) begin
            unique case (reg_idx)
                rpu_pkg::REG_PIXEL_SIZE_MODE: r_cfg.pixel_size_mode <= pwdata[2:0];
                rpu_pkg::REG_OUTPUT_FORMAT:   r_cfg.output_format   <= pwdata[1:0];
                rpu_pkg::REG_UYVY_MODE:       r_cfg.uyvy_mode       <= pwdata[0];
                rpu_pkg::REG_SWAP_BGR:        r_cfg.swap_bgr        <= pwdata[0];
                rpu_pkg::REG_ALPHA_VALUE:     r_cfg.alpha_value     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rpu_pkg::REG_PIXEL_SIZE_MODE: prdata[2:0] = r_cfg.pixel_size_mode;
            rpu_pkg::REG_OUTPUT_FORMAT:   prdata[1:0] = r_cfg.output_format;
            rpu_pkg::REG_UYVY_MODE:       prdata[0]   = r_cfg.uyvy_mode;
            rpu_pkg::REG_SWAP_BGR:        prdata[0]   = r_cfg.swap_bgr;
            rpu_pkg::REG_ALPHA_VALUE:     prdata[7:0] = r_cfg.alpha_value;
            default: ;
        endcase
    end

endmodule

### rtl/rpu_front.sv
// input stage: beat capture, packed run clipping, chroma state and yuv products
`timescale 1ns / 1ps

module rpu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpu_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [31:0]    i_raw_pixel,
    input  logic           i_first_in_line,
    input  logic [2:0]     i_start_offset,
    input  logic [3:0]     i_pixel_count,
    input  logic [7:0]     i_lookahead_chroma,
    input  logic           i_take,
    output logic           o_item_valid,
    output rpu_pkg::t_item o_item
);

    logic           r_valid;
    rpu_pkg::t_item r_item;
    logic [7:0]     r_held_u;
    logic [7:0]     r_held_v;
    logic           r_parity;

    logic [7:0]     n_held_u;
    logic [7:0]     n_held_v;
    logic           n_parity;
    rpu_pkg::t_item n_item;

    logic           accept;
    logic           produces;
    logic           uyvy_colour;
    logic [3:0]     avail;
    logic [3:0]     cnt;
    logic [2:0]     start_eff;
    logic signed [9:0] y_s;
    logic signed [9:0] u_s;
    logic signed [9:0] v_s;

    assign o_in_stall   = r_valid & ~i_take;
    assign accept       = i_in_valid & ~o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    assign uyvy_colour = (i_cfg.pixel_size_mode == rpu_pkg::PSM_16BIT) & i_cfg.uyvy_mode
                       & ((i_cfg.output_format == rpu_pkg::FMT_RGB)
                       || (i_cfg.output_format == rpu_pkg::FMT_RGBA));

    // packed run clipping
    always_comb begin
        if (i_cfg.pixel_size_mode == rpu_pkg::PSM_4BIT) begin
            start_eff = {2'b00, i_start_offset[0]};
            avail     = 4'd2 - {3'b000, i_start_offset[0]};
        end else begin
            start_eff = i_start_offset;
            avail     = 4'd8 - {1'b0, i_start_offset};
        end
        cnt = (i_pixel_count > avail) ? avail : i_pixel_count;
    end

    always_comb begin
        produces = 1'b0;
        if (i_cfg.output_format <= rpu_pkg::FMT_RGBA) begin
            unique case (i_cfg.pixel_size_mode)
                rpu_pkg::PSM_1BIT,
                rpu_pkg::PSM_4BIT:  produces = (cnt != 4'd0);
                rpu_pkg::PSM_8BIT:  produces = 1'b1;
                rpu_pkg::PSM_16BIT: produces = i_cfg.uyvy_mode
                                             | (i_cfg.output_format != rpu_pkg::FMT_LUMA);
                rpu_pkg::PSM_24BIT,
                rpu_pkg::PSM_32BIT: produces = (i_cfg.output_format != rpu_pkg::FMT_LUMA);
                default:            produces = 1'b0;
            endcase
        end
    end

    // chroma tracking
    always_comb begin
        n_held_u = r_held_u;
        n_held_v = r_held_v;
        n_parity = i_first_in_line ? i_start_offset[0] : r_parity;
        if (i_first_in_line) begin
            if (n_parity) begin
                n_held_u = i_lookahead_chroma;
            end else begin
                n_held_v = i_lookahead_chroma;
            end
        end
        if (n_parity) begin
            n_held_v = i_raw_pixel[7:0];
        end else begin
            n_held_u = i_raw_pixel[7:0];
        end
    end

    always_comb begin
        y_s = $signed({2'b00, i_raw_pixel[15:8]}) - 10'sd16;
        u_s = $signed({2'b00, n_held_u}) - 10'sd128;
        v_s = $signed({2'b00, n_held_v}) - 10'sd128;
        n_item.b0       = i_raw_pixel[7:0];
        n_item.b1       = i_raw_pixel[15:8];
        n_item.b2       = i_raw_pixel[23:16];
        n_item.start    = start_eff;
        n_item.last_idx = (i_cfg.pixel_size_mode == rpu_pkg::PSM_1BIT
                        || i_cfg.pixel_size_mode == rpu_pkg::PSM_4BIT)
                        ? 3'(cnt - 4'd1) : 3'd0;
        n_item.y_p      = 29'(y_s) * 29'(rpu_pkg::K_Y);
        n_item.rv_p     = 29'(v_s) * 29'(rpu_pkg::K_RV);
        n_item.gv_p     = 29'(v_s) * 29'(rpu_pkg::K_GV);
        n_item.gu_p     = 29'(u_s) * 29'(rpu_pkg::K_GU);
        n_item.bu_p     = 29'(u_s) * 29'(rpu_pkg::K_BU);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_held_u <= 8'd128;
            r_held_v <= 8'd128;
            r_parity <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= produces;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
            if (accept && produces && uyvy_colour) begin
                r_held_u <= n_held_u;
                r_held_v <= n_held_v;
                r_parity <= ~n_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/rpu_back.sv
// result stage: per-pixel formatting, packed run counter and output register
`timescale 1ns / 1ps

module rpu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpu_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    input  rpu_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte0,
    output logic [7:0]     o_out_byte1,
    output logic [7:0]     o_out_byte2,
    output logic [7:0]     o_out_byte3,
    output logic [2:0]     o_byte_count,
    output logic           o_last_of_run
);

    logic       r_out_valid;
    logic [2:0] r_idx;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [7:0] r_b2;
    logic [7:0] r_b3;
    logic [2:0] r_cnt;
    logic       r_last;

    logic [7:0] n_b0;
    logic [7:0] n_b1;
    logic [7:0] n_b2;
    logic [7:0] n_b3;
    logic [2:0] n_cnt;

    logic       out_free;
    logic       advance;
    logic       is_last;
    logic [2:0] pos;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] ca;
    logic [7:0] yuv_r;
    logic [7:0] yuv_g;
    logic [7:0] yuv_b;
    logic       colour;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign advance  = i_item_valid & out_free;
    assign is_last  = (r_idx == i_item.last_idx);
    assign o_take   = advance & is_last;
    assign pos      = i_item.start + r_idx;

    assign yuv_r = rpu_pkg::clamp_channel(30'(i_item.y_p) + 30'(i_item.rv_p));
    assign yuv_g = rpu_pkg::clamp_channel(30'(i_item.y_p) - 30'(i_item.gv_p)
                                          - 30'(i_item.gu_p));
    assign yuv_b = rpu_pkg::clamp_channel(30'(i_item.y_p) + 30'(i_item.bu_p));

    always_comb begin
        colour = 1'b0;
        c0     = i_item.b0;
        c1     = i_item.b1;
        c2     = i_item.b2;
        ca     = i_cfg.alpha_value;
        n_b0   = 8'd0;
        n_b1   = 8'd0;
        n_b2   = 8'd0;
        n_b3   = 8'd0;
        n_cnt  = rpu_pkg::BYTES_LUMA;
        unique case (i_cfg.pixel_size_mode)
            rpu_pkg::PSM_1BIT: begin
                n_b0 = i_item.b0[pos] ? 8'hFF : 8'h00;
            end
            rpu_pkg::PSM_4BIT: begin
                n_b0 = pos[0] ? {i_item.b0[7:4], 4'h0} : {i_item.b0[3:0], 4'h0};
            end
            rpu_pkg::PSM_8BIT: begin
                n_b0   = i_item.b0;
                colour = (i_cfg.output_format != rpu_pkg::FMT_LUMA);
                c1     = i_item.b0;
                c2     = i_item.b0;
            end
            rpu_pkg::PSM_16BIT: begin
                if (i_cfg.uyvy_mode) begin
                    n_b0   = i_item.b1;
                    colour = (i_cfg.output_format != rpu_pkg::FMT_LUMA);
                    c0     = yuv_r;
                    c1     = yuv_g;
                    c2     = yuv_b;
                end else begin
                    colour = 1'b1;
                    c0     = {i_item.b1[6:2], 3'b000};
                    c1     = {i_item.b1[1:0], i_item.b0[7:5], 3'b000};
                    c2     = {i_item.b0[4:0], 3'b000};
                end
            end
            rpu_pkg::PSM_24BIT: begin
                colour = 1'b1;
                if (i_cfg.swap_bgr) begin
                    c0 = i_item.b2;
                    c2 = i_item.b0;
                end
            end
            rpu_pkg::PSM_32BIT: begin
                colour = 1'b1;
                if (i_cfg.output_format == rpu_pkg::FMT_RGB || i_cfg.swap_bgr) begin
                    c0 = i_item.b2;
                    c2 = i_item.b0;
                end else begin
                    ca = 8'hFF;
                end
            end
            default: ;
        endcase
        if (colour) begin
            n_b0 = c0;
            n_b1 = c1;
            n_b2 = c2;
            if (i_cfg.output_format == rpu_pkg::FMT_RGB) begin
                n_cnt = rpu_pkg::BYTES_RGB;
            end else begin
                n_b3  = ca;
                n_cnt = rpu_pkg::BYTES_RGBA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            if (out_free) begin
                r_out_valid <= i_item_valid;
            end
            if (advance) begin
                r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b0   <= n_b0;
            r_b1   <= n_b1;
            r_b2   <= n_b2;
            r_b3   <= n_b3;
            r_cnt  <= n_cnt;
            r_last <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte0   = r_b0;
    assign o_out_byte1   = r_b1;
    assign o_out_byte2   = r_b2;
    assign o_out_byte3   = r_b3;
    assign o_byte_count  = r_cnt;
    assign o_last_of_run = r_last;

endmodule

### rtl/raster_pixel_unpacker_top.sv
// top level of the raster pixel unpacker
`timescale 1ns / 1ps

// Converts one raw grabber pixel per input beat into luminance, RGB or RGBA
// output beats. Every accepted input beat yields one output beat, one per
// cycle while the output is not stalled, except packed 1-bit and 4-bit bytes,
// which yield one beat per unpacked pixel (up to 8 for a 1-bit byte, up to 2
// for a 4-bit byte), paced by the pixel counter in the result stage. A beat
// passes through the input register, then the output register. Unsupported
// mode combinations and empty packed runs are taken and give no output beat.
// The user must write registers over the APB port only while the block is
// idle; the block does not check it. No clearing pass is needed after reset.

module raster_pixel_unpacker_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpu_pkg::PADDR_W-1:0]  paddr,
    input  logic [rpu_pkg::PDATA_W-1:0]  pwdata,
    output logic [rpu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [31:0]                  i_raw_pixel,
    input  logic                         i_first_in_line,
    input  logic [2:0]                   i_start_offset,
    input  logic [3:0]                   i_pixel_count,
    input  logic [7:0]                   i_lookahead_chroma,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_out_byte0,
    output logic [7:0]                   o_out_byte1,
    output logic [7:0]                   o_out_byte2,
    output logic [7:0]                   o_out_byte3,
    output logic [2:0]                   o_byte_count,
    output logic                         o_last_of_run
);

    rpu_pkg::t_cfg  cfg;
    rpu_pkg::t_item item;
    logic           item_valid;
    logic           take;

    rpu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpu_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_raw_pixel        (i_raw_pixel),
        .i_first_in_line    (i_first_in_line),
        .i_start_offset     (i_start_offset),
        .i_pixel_count      (i_pixel_count),
        .i_lookahead_chroma (i_lookahead_chroma),
        .i_take             (take),
        .o_item_valid       (item_valid),
        .o_item             (item)
    );

    rpu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_take        (take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte0   (o_out_byte0),
        .o_out_byte1   (o_out_byte1),
        .o_out_byte2   (o_out_byte2),
        .o_out_byte3   (o_out_byte3),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### test/tb_top.sv
// self-checking testbench for the raster pixel unpacker: directed and random pixels, stalls
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int BLOCKS = 17;
    localparam int BLOCK_ITEMS = 12;

    localparam logic [2:0] PSM_RSVD6 = 3'd6;
    localparam logic [2:0] PSM_RSVD7 = 3'd7;
    localparam logic [1:0] FMT_RSVD = 2'd3;

    localparam int C_Y  = 76284;
    localparam int C_RV = 104595;
    localparam int C_GV = 53281;
    localparam int C_GU = 25625;
    localparam int C_BU = 132252;
    localparam int C_RND = 32768;

    typedef struct {
        logic [31:0] raw;
        logic        first;
        logic [2:0]  start;
        logic [3:0]  count;
        logic [7:0]  look;
    } t_pix_in;

    typedef struct {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] nbytes;
        logic       last;
    } t_pix_beat;

    class t_unpack_scoreboard;
        logic [2:0] psm;
        logic [1:0] fmt;
        logic       uyvy;
        logic       swap;
        logic [7:0] alpha;
        logic [7:0] held_u;
        logic [7:0] held_v;
        logic       parity;
        t_pix_beat  pending_pixels[$];
        int         errors;
        int         pixels_in;
        int         beats_out;

        function new();
            psm = rpu_pkg::PSM_8BIT;
            fmt = rpu_pkg::FMT_LUMA;
            uyvy = 1'b0;
            swap = 1'b0;
            alpha = 8'hFF;
            held_u = 8'd128;
            held_v = 8'd128;
            parity = 1'b0;
            errors = 0;
            pixels_in = 0;
            beats_out = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                rpu_pkg::REG_PIXEL_SIZE_MODE: psm = val[2:0];
                rpu_pkg::REG_OUTPUT_FORMAT:   fmt = val[1:0];
                rpu_pkg::REG_UYVY_MODE:       uyvy = val[0];
                rpu_pkg::REG_SWAP_BGR:        swap = val[0];
                rpu_pkg::REG_ALPHA_VALUE:     alpha = val[7:0];
                default: ;
            endcase
        endfunction

        function t_pix_beat beat(input logic [7:0] c0, c1, c2, c3, input logic [2:0] nb);
            t_pix_beat p;
            p.b0 = c0;
            p.b1 = c1;
            p.b2 = c2;
            p.b3 = c3;
            p.nbytes = nb;
            p.last = 1'b0;
            return p;
        endfunction

        function t_pix_beat luma(input logic [7:0] c);
            return beat(c, 8'h00, 8'h00, 8'h00, rpu_pkg::BYTES_LUMA);
        endfunction

        function t_pix_beat colour(input logic [7:0] c0, c1, c2);
            if (fmt == rpu_pkg::FMT_RGB) begin
                return beat(c0, c1, c2, 8'h00, rpu_pkg::BYTES_RGB);
            end
            return beat(c0, c1, c2, alpha, rpu_pkg::BYTES_RGBA);
        endfunction

        function logic [7:0] sat_channel(input int acc);
            int x;
            x = acc + C_RND;
            if (x < 0) begin
                return 8'h00;
            end
            x = x >>> 16;
            if (x > 255) begin
                return 8'hFF;
            end
            return x[7:0];
        endfunction

        function void predict_pixel(t_pix_in it);
            t_pix_beat  run[8];
            int         n;
            int         cnt;
            int         avail;
            int         s;
            int         i;
            int         yb;
            int         y;
            int         u;
            int         v;
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b2;
            logic [15:0] w;
            b0 = it.raw[7:0];
            b1 = it.raw[15:8];
            b2 = it.raw[23:16];
            w = it.raw[15:0];
            n = 0;
            pixels_in++;
            if (fmt > rpu_pkg::FMT_RGBA) begin
                return;
            end
            case (psm)
                rpu_pkg::PSM_1BIT: begin
                    avail = 8 - int'(it.start);
                    cnt = int'(it.count);
                    if (cnt > avail) begin
                        cnt = avail;
                    end
                    for (i = 0; i < cnt; i++) begin
                        run[n] = luma(b0[3'(int'(it.start) + i)] ? 8'hFF : 8'h00);
                        n++;
                    end
                end
                rpu_pkg::PSM_4BIT: begin
                    s = int'(it.start[0]);
                    avail = 2 - s;
                    cnt = int'(it.count);
                    if (cnt > avail) begin
                        cnt = avail;
                    end
                    for (i = 0; i < cnt; i++) begin
                        run[n] = luma({b0[3'((s + i) * 4) +: 4], 4'h0});
                        n++;
                    end
                end
                rpu_pkg::PSM_8BIT: begin
                    if (fmt == rpu_pkg::FMT_LUMA) begin
                        run[0] = luma(b0);
                    end else begin
                        run[0] = colour(b0, b0, b0);
                    end
                    n = 1;
                end
                rpu_pkg::PSM_16BIT: begin
                    if (uyvy) begin
                        if (fmt == rpu_pkg::FMT_LUMA) begin
                            run[0] = luma(b1);
                        end else begin
                            if (it.first) begin
                                parity = it.start[0];
                                if (parity) begin
                                    held_u = it.look;
                                end else begin
                                    held_v = it.look;
                                end
                            end
                            if (parity) begin
                                held_v = b0;
                            end else begin
                                held_u = b0;
                            end
                            parity = ~parity;
                            yb = int'(b1);
                            y = (yb - 16) * C_Y;
                            u = int'(held_u);
                            u = u - 128;
                            v = int'(held_v);
                            v = v - 128;
                            run[0] = colour(sat_channel(y + C_RV * v),
                                            sat_channel(y - C_GV * v - C_GU * u),
                                            sat_channel(y + C_BU * u));
                        end
                        n = 1;
                    end else if (fmt != rpu_pkg::FMT_LUMA) begin
                        run[0] = colour({w[14:10], 3'b000}, {w[9:5], 3'b000},
                                        {w[4:0], 3'b000});
                        n = 1;
                    end
                end
                rpu_pkg::PSM_24BIT: begin
                    if (fmt != rpu_pkg::FMT_LUMA) begin
                        if (swap) begin
                            run[0] = colour(b2, b1, b0);
                        end else begin
                            run[0] = colour(b0, b1, b2);
                        end
                        n = 1;
                    end
                end
                rpu_pkg::PSM_32BIT: begin
                    if (fmt == rpu_pkg::FMT_RGB) begin
                        run[0] = beat(b2, b1, b0, 8'h00, rpu_pkg::BYTES_RGB);
                        n = 1;
                    end else if (fmt == rpu_pkg::FMT_RGBA) begin
                        if (swap) begin
                            run[0] = beat(b2, b1, b0, alpha, rpu_pkg::BYTES_RGBA);
                        end else begin
                            run[0] = beat(b0, b1, b2, 8'hFF, rpu_pkg::BYTES_RGBA);
                        end
                        n = 1;
                    end
                end
                default: ;
            endcase
            if (n > 0) begin
                run[n - 1].last = 1'b1;
            end
            for (i = 0; i < n; i++) begin
                pending_pixels.push_back(run[i]);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("tb_top: mismatch: %s", msg);
            end
        endtask

        task check_beat(t_pix_beat got);
            t_pix_beat want;
            beats_out++;
            if (pending_pixels.size() == 0) begin
                report($sformatf("beat %0d unexpected: %02h %02h %02h %02h n%0d l%0b",
                                 beats_out, got.b0, got.b1, got.b2, got.b3,
                                 got.nbytes, got.last));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.b0 !== want.b0 || got.b1 !== want.b1 || got.b2 !== want.b2 ||
                got.b3 !== want.b3 || got.nbytes !== want.nbytes ||
                got.last !== want.last) begin
                report($sformatf({"beat %0d got %02h %02h %02h %02h n%0d l%0b",
                                  " want %02h %02h %02h %02h n%0d l%0b"},
                                 beats_out, got.b0, got.b1, got.b2, got.b3, got.nbytes,
                                 got.last, want.b0, want.b1, want.b2, want.b3,
                                 want.nbytes, want.last));
            end
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [rpu_pkg::PADDR_W-1:0] paddr = '0;
    logic [rpu_pkg::PDATA_W-1:0] pwdata = '0;
    logic [rpu_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [31:0]                 i_raw_pixel = '0;
    logic                        i_first_in_line = 1'b0;
    logic [2:0]                  i_start_offset = '0;
    logic [3:0]                  i_pixel_count = '0;
    logic [7:0]                  i_lookahead_chroma = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [7:0]                  o_out_byte0;
    logic [7:0]                  o_out_byte1;
    logic [7:0]                  o_out_byte2;
    logic [7:0]                  o_out_byte3;
    logic [2:0]                  o_byte_count;
    logic                        o_last_of_run;

    t_unpack_scoreboard sb;
    int        cycle_count = 0;
    int        tx_idle_pct = 24;
    int        rx_idle_pct = 50;
    int        hold_left = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        reg_writes = 0;
    t_pix_in   in_beat;
    t_pix_beat out_beat;

    raster_pixel_unpacker_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_raw_pixel        (i_raw_pixel),
        .i_first_in_line    (i_first_in_line),
        .i_start_offset     (i_start_offset),
        .i_pixel_count      (i_pixel_count),
        .i_lookahead_chroma (i_lookahead_chroma),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte0        (o_out_byte0),
        .o_out_byte1        (o_out_byte1),
        .o_out_byte2        (o_out_byte2),
        .o_out_byte3        (o_out_byte3),
        .o_byte_count       (o_byte_count),
        .o_last_of_run      (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: random stall, or a long hold when asked
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_beat.raw = i_raw_pixel;
            in_beat.first = i_first_in_line;
            in_beat.start = i_start_offset;
            in_beat.count = i_pixel_count;
            in_beat.look = i_lookahead_chroma;
            sb.predict_pixel(in_beat);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_beat.b0 = o_out_byte0;
            out_beat.b1 = o_out_byte1;
            out_beat.b2 = o_out_byte2;
            out_beat.b3 = o_out_byte3;
            out_beat.nbytes = o_byte_count;
            out_beat.last = o_last_of_run;
            sb.check_beat(out_beat);
        end
    end

    task send_pixel(input logic [31:0] raw, input logic first, input logic [2:0] start,
                    input logic [3:0] count, input logic [7:0] look);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_pixel <= raw;
        i_first_in_line <= first;
        i_start_offset <= start;
        i_pixel_count <= count;
        i_lookahead_chroma <= look;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // lets every predicted beat come out, then waits SETTLE_CYCLES for runs with no output
    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.set_reg(idx, data);
        reg_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task set_cfg(input logic [2:0] psm, input logic [1:0] fmt, input logic uyvy,
                 input logic swap, input logic [7:0] alpha);
        drain();
        apb_write(rpu_pkg::REG_PIXEL_SIZE_MODE, {29'd0, psm});
        apb_write(rpu_pkg::REG_OUTPUT_FORMAT, {30'd0, fmt});
        apb_write(rpu_pkg::REG_UYVY_MODE, {31'd0, uyvy});
        apb_write(rpu_pkg::REG_SWAP_BGR, {31'd0, swap});
        apb_write(rpu_pkg::REG_ALPHA_VALUE, {24'd0, alpha});
    endtask

    initial begin
        int          blk;
        int          k;
        int          r;
        logic [2:0]  psm;
        logic [1:0]  fmt;
        logic        uyvy;
        logic        swap;
        logic [7:0]  alpha;
        logic        line_mode;
        logic [31:0] raw;
        logic        first;
        logic [3:0]  count;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 8-bit luminance
        send_pixel(32'h000000FF, 1'b0, 3'd0, 4'd1, 8'h00);
        send_pixel(32'hFFFFFF00, 1'b1, 3'd7, 4'd8, 8'hFF);

        set_cfg(rpu_pkg::PSM_1BIT, rpu_pkg::FMT_LUMA, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h000000A5, 1'b0, 3'd0, 4'd8, 8'h00);
        send_pixel(32'h00000080, 1'b0, 3'd7, 4'd8, 8'h00);
        send_pixel(32'h000000FF, 1'b0, 3'd3, 4'd0, 8'h00);
        send_pixel(32'h000000FF, 1'b0, 3'd0, 4'd15, 8'h00);

        set_cfg(rpu_pkg::PSM_4BIT, rpu_pkg::FMT_RGBA, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h0000003C, 1'b0, 3'd0, 4'd2, 8'h00);
        send_pixel(32'h000000F0, 1'b0, 3'd5, 4'd2, 8'h00);
        send_pixel(32'h0000000F, 1'b0, 3'd0, 4'd1, 8'h00);

        set_cfg(rpu_pkg::PSM_8BIT, rpu_pkg::FMT_RGBA, 1'b0, 1'b0, 8'h00);
        send_pixel(32'h00000080, 1'b0, 3'd0, 4'd1, 8'h00);

        // uyvy lines with both start parities and chroma extremes
        set_cfg(rpu_pkg::PSM_16BIT, rpu_pkg::FMT_RGB, 1'b1, 1'b0, 8'hFF);
        send_pixel(32'h0000FF00, 1'b1, 3'd0, 4'd1, 8'hFF);
        send_pixel(32'h000010FF, 1'b0, 3'd0, 4'd1, 8'h00);
        send_pixel(32'h0000EB80, 1'b1, 3'd3, 4'd1, 8'h00);
        set_cfg(rpu_pkg::PSM_16BIT, rpu_pkg::FMT_LUMA, 1'b1, 1'b0, 8'hFF);
        send_pixel(32'h00001234, 1'b1, 3'd1, 4'd1, 8'h55);

        set_cfg(rpu_pkg::PSM_16BIT, rpu_pkg::FMT_RGBA, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h0000FFFF, 1'b0, 3'd0, 4'd1, 8'h00);
        send_pixel(32'h00008000, 1'b0, 3'd0, 4'd1, 8'h00);
        set_cfg(rpu_pkg::PSM_16BIT, rpu_pkg::FMT_LUMA, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h00007FFF, 1'b0, 3'd0, 4'd1, 8'h00);

        set_cfg(rpu_pkg::PSM_24BIT, rpu_pkg::FMT_RGB, 1'b0, 1'b1, 8'hFF);
        send_pixel(32'h00112233, 1'b0, 3'd0, 4'd1, 8'h00);
        set_cfg(rpu_pkg::PSM_24BIT, rpu_pkg::FMT_LUMA, 1'b0, 1'b1, 8'hFF);
        send_pixel(32'h00112233, 1'b0, 3'd0, 4'd1, 8'h00);

        set_cfg(rpu_pkg::PSM_32BIT, rpu_pkg::FMT_RGB, 1'b0, 1'b0, 8'h40);
        send_pixel(32'hFF112233, 1'b0, 3'd0, 4'd1, 8'h00);
        set_cfg(rpu_pkg::PSM_32BIT, rpu_pkg::FMT_RGBA, 1'b0, 1'b0, 8'h40);
        send_pixel(32'h44556677, 1'b0, 3'd0, 4'd1, 8'h00);
        set_cfg(rpu_pkg::PSM_32BIT, rpu_pkg::FMT_RGBA, 1'b0, 1'b1, 8'h00);
        send_pixel(32'h44556677, 1'b0, 3'd0, 4'd1, 8'h00);

        set_cfg(rpu_pkg::PSM_8BIT, FMT_RSVD, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h000000AA, 1'b0, 3'd0, 4'd1, 8'h00);
        set_cfg(PSM_RSVD7, rpu_pkg::FMT_RGB, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h000000AA, 1'b0, 3'd0, 4'd1, 8'h00);
        set_cfg(PSM_RSVD6, rpu_pkg::FMT_RGB, 1'b0, 1'b0, 8'hFF);
        send_pixel(32'h000000AA, 1'b0, 3'd0, 4'd1, 8'h00);

        for (blk = 0; blk < BLOCKS; blk++) begin
            if (blk == 6) begin
                tx_idle_pct = 50;
                rx_idle_pct = 24;
            end
            if (blk == 12) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = $urandom_range(0, 19);
            if (r < 2) psm = rpu_pkg::PSM_1BIT;
            else if (r < 4) psm = rpu_pkg::PSM_4BIT;
            else if (r < 6) psm = rpu_pkg::PSM_8BIT;
            else if (r < 13) psm = rpu_pkg::PSM_16BIT;
            else if (r < 15) psm = rpu_pkg::PSM_24BIT;
            else if (r < 18) psm = rpu_pkg::PSM_32BIT;
            else psm = r[0] ? PSM_RSVD7 : PSM_RSVD6;
            r = $urandom_range(0, 9);
            if (r < 2) fmt = rpu_pkg::FMT_LUMA;
            else if (r < 6) fmt = rpu_pkg::FMT_RGB;
            else if (r < 9) fmt = rpu_pkg::FMT_RGBA;
            else fmt = FMT_RSVD;
            uyvy = ($urandom_range(0, 3) != 0);
            swap = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 5);
            if (r == 0) alpha = 8'h00;
            else if (r == 1) alpha = 8'hFF;
            else alpha = 8'($urandom_range(0, 255));
            // long hold block uses 1-bit luminance, which gives output for every beat with a nonzero pixel count
            if (blk == 12) begin
                psm = rpu_pkg::PSM_1BIT;
                fmt = rpu_pkg::FMT_LUMA;
            end
            set_cfg(psm, fmt, uyvy, swap, alpha);
            if (blk == 12) begin
                hold_req = 1'b1;
            end
            line_mode = (psm == rpu_pkg::PSM_16BIT) && uyvy && (fmt != rpu_pkg::FMT_LUMA);
            for (k = 0; k < BLOCK_ITEMS; k++) begin
                r = $urandom_range(0, 9);
                if (r == 0) raw = 32'h00000000;
                else if (r == 1) raw = 32'hFFFFFFFF;
                else raw = $urandom;
                if (line_mode) begin
                    first = (k == 0) || ($urandom_range(0, 9) == 0);
                end else begin
                    first = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 9) == 0) begin
                    count = 4'($urandom_range(0, 15));
                end else begin
                    count = 4'($urandom_range(1, 8));
                end
                send_pixel(raw, first, 3'($urandom_range(0, 7)), count,
                           8'($urandom_range(0, 255)));
            end
        end

        drain();
        if (sb.pending_pixels.size() != 0) begin
            sb.report($sformatf("%0d beats never came out", sb.pending_pixels.size()));
        end
        $display("tb_top: %0d pixels in, %0d beats checked, %0d register writes",
                 sb.pixels_in, sb.beats_out, reg_writes);
        $display("tb_top: all pixel sizes and formats incl. reserved, uyvy lines, swap, long hold");
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### raster_pixel_unpacker_top.f
rtl/rpu_pkg.sv
rtl/rpu_cfg.sv
rtl/rpu_front.sv
rtl/rpu_back.sv
rtl/raster_pixel_unpacker_top.sv
test/tb_top.sv
